/* src/clr_pkg.sv */
// Shared constants for the clipped line rasterizer: widths, codes and reset values.
package clr_pkg;

  // Default widths
  localparam int COORD_WIDTH_DEF = 12;
  localparam int COLOR_WIDTH_DEF = 24;

  // Configuration port index width
  localparam int CFG_INDEX_WIDTH = 2;

  // Command codes on the line channel
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Clip window register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_index_t;

  // Clip window reset values
  localparam int CLIP_LEFT_RST   = 10;
  localparam int CLIP_TOP_RST    = 82;
  localparam int CLIP_RIGHT_RST  = 1140;
  localparam int CLIP_BOTTOM_RST = 560;

endpackage

/* src/clr_line_if.sv */
// Line command channel: valid/ready handshake with load or step payload.
interface clr_line_if #(
  parameter int COORD_WIDTH = clr_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = clr_pkg::COLOR_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic        [COLOR_WIDTH-1:0] line_color;

  modport source (
    output valid, cmd, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, cmd, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

/* src/clr_pixel_if.sv */
// Pixel result channel: valid/ready handshake with pixel payload.
interface clr_pixel_if #(
  parameter int COORD_WIDTH = clr_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = clr_pkg::COLOR_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pixel_x;
  logic signed [COORD_WIDTH-1:0] pixel_y;
  logic        [COLOR_WIDTH-1:0] pixel_color;
  logic                          inside_res;
  logic                          last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, inside_res, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, inside_res, last_pixel,
    output ready
  );
endinterface

/* src/clipped_line_rasterizer.sv */
// Bresenham line walker with a rectangular clip window.
//
// Channels: line_in takes beats with cmd = load (endpoints and color) or
// cmd = step. A load sets up the line and gives no pixel; it replaces any
// line in progress. Each step on an active line gives one beat on pixel_out
// holding the current pixel, its color, an inside-window flag and a flag on
// the final endpoint. A step with no active line is consumed silently.
// The clip window lives in four registers written over cfg_we/cfg_index/
// cfg_data; writes to them are meant to happen while the block is idle.
//
// Output: a step's pixel is written into the output register when the step is
// accepted. Throughput: one beat per cycle while pixel_out is not stalled, as the
// walker state (error term add and compare) is updated on each accepted step.
// Stall: pixel_out is a single output register; line_in.ready is high when
// that register is empty or being drained in the same cycle, so the walker
// holds still while the receiver stalls.
// Reset: no line is active, the output register is empty and the clip
// window returns to left 10, top 82, right 1140, bottom 560.
module clipped_line_rasterizer #(
  parameter int COORD_WIDTH = clr_pkg::COORD_WIDTH_DEF,
  parameter int COLOR_WIDTH = clr_pkg::COLOR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [clr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  clr_line_if.sink                            line_in,
  clr_pixel_if.source                         pixel_out
);
  import clr_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = COORD_WIDTH + 1;  // endpoint difference
  localparam int EW  = COORD_WIDTH + 2;  // error term
  localparam int E2W = COORD_WIDTH + 3;  // doubled error term

  // Clip window registers
  logic signed [CW-1:0] clip_left, clip_top, clip_right, clip_bottom;

  // Walker state
  logic signed [CW-1:0]    cur_x, cur_y, target_x, target_y;
  logic        [CW-1:0]    span_x, span_y;
  logic                    dir_x_neg, dir_y_neg;
  logic signed [EW-1:0]    err_term;
  logic [COLOR_WIDTH-1:0]  held_color;
  logic                    active;

  // Output register
  logic                   out_valid;
  logic signed [CW-1:0]   out_x, out_y;
  logic [COLOR_WIDTH-1:0] out_color;
  logic                   out_inside, out_last;

  logic accept, is_load, is_step, emit;

  // Load setup
  logic signed [DW-1:0] diff_x, diff_y;
  logic        [CW-1:0] load_span_x, load_span_y;
  logic signed [EW-1:0] load_err;

  // Step evaluation
  logic                  in_window, last;
  logic signed [E2W-1:0] e2, span_x_ext, span_y_ext;
  logic                  step_x, step_y;
  logic signed [EW-1:0]  err_sub, err_add, err_next;
  logic signed [CW-1:0]  cur_x_next, cur_y_next;

  // Handshake
  assign line_in.ready = !out_valid || pixel_out.ready;
  assign accept        = line_in.valid && line_in.ready;
  assign is_load       = accept && (line_in.cmd == CMD_LOAD);
  assign is_step       = accept && (line_in.cmd == CMD_STEP);
  assign emit          = is_step && active;

  // Spans, directions and starting error of a new line
  assign diff_x      = DW'(line_in.end_x) - DW'(line_in.start_x);
  assign diff_y      = DW'(line_in.end_y) - DW'(line_in.start_y);
  assign load_span_x = diff_x[DW-1] ? CW'(-diff_x) : CW'(diff_x);
  assign load_span_y = diff_y[DW-1] ? CW'(-diff_y) : CW'(diff_y);
  assign load_err    = $signed({2'b00, load_span_x}) - $signed({2'b00, load_span_y});

  // Window test and end point test on the current pixel
  assign in_window = (cur_x >= clip_left) && (cur_x <= clip_right) &&
                     (cur_y >= clip_top)  && (cur_y <= clip_bottom);
  assign last      = (cur_x == target_x) && (cur_y == target_y);

  // Error rule
  assign e2         = {err_term, 1'b0};
  assign span_x_ext = $signed({3'b000, span_x});
  assign span_y_ext = $signed({3'b000, span_y});
  assign step_x     = e2 > -span_y_ext;
  assign step_y     = e2 < span_x_ext;
  assign err_sub    = step_x ? $signed({2'b00, span_y}) : $signed({EW{1'b0}});
  assign err_add    = step_y ? $signed({2'b00, span_x}) : $signed({EW{1'b0}});
  assign err_next   = err_term - err_sub + err_add;
  assign cur_x_next = cur_x + (dir_x_neg ? $signed({CW{1'b1}}) : $signed(CW'(1)));
  assign cur_y_next = cur_y + (dir_y_neg ? $signed({CW{1'b1}}) : $signed(CW'(1)));

  // Clip window writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= CW'(CLIP_LEFT_RST);
      clip_top    <= CW'(CLIP_TOP_RST);
      clip_right  <= CW'(CLIP_RIGHT_RST);
      clip_bottom <= CW'(CLIP_BOTTOM_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP_LEFT:   clip_left   <= cfg_data;
        CFG_CLIP_TOP:    clip_top    <= cfg_data;
        CFG_CLIP_RIGHT:  clip_right  <= cfg_data;
        CFG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walker state update
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      target_x   <= '0;
      target_y   <= '0;
      span_x     <= '0;
      span_y     <= '0;
      dir_x_neg  <= 1'b0;
      dir_y_neg  <= 1'b0;
      err_term   <= '0;
      held_color <= '0;
      active     <= 1'b0;
    end else if (is_load) begin
      cur_x      <= line_in.start_x;
      cur_y      <= line_in.start_y;
      target_x   <= line_in.end_x;
      target_y   <= line_in.end_y;
      span_x     <= load_span_x;
      span_y     <= load_span_y;
      dir_x_neg  <= !(line_in.start_x < line_in.end_x);
      dir_y_neg  <= !(line_in.start_y < line_in.end_y);
      err_term   <= load_err;
      held_color <= line_in.line_color;
      active     <= 1'b1;
    end else if (emit) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        err_term <= err_next;
        if (step_x) begin
          cur_x <= cur_x_next;
        end
        if (step_y) begin
          cur_y <= cur_y_next;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (line_in.ready) begin
      out_valid <= emit;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x      <= cur_x;
      out_y      <= cur_y;
      out_color  <= held_color;
      out_inside <= in_window;
      out_last   <= last;
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_x     = out_x;
  assign pixel_out.pixel_y     = out_y;
  assign pixel_out.pixel_color = out_color;
  assign pixel_out.inside_res  = out_inside;
  assign pixel_out.last_pixel  = out_last;

endmodule
